@@ hdl/qxm_pkg.sv @@
package qxm_pkg;

  // field widths
  localparam int FRAC_BITS = 4;
  localparam int IN_W      = 15;
  localparam int CFG_W     = 15;
  localparam int US_W      = 15;
  localparam int DUTY_W    = 16;

  // mixed width, signed, holds T plus three torques
  localparam int W_W   = IN_W + 4;
  // limit in sub-microsecond units, unsigned
  localparam int LIM_W = CFG_W + FRAC_BITS;
  // signed domain for width against limit compares
  localparam int CMP_W = LIM_W + 2;

  // gamma, unsigned with 16 fraction bits
  localparam int GAMMA_FRAC = 16;
  localparam int GAMMA_W    = 32;

  // divider: numerator is limit << GAMMA_FRAC, divisor a positive width
  localparam int NUM_W = LIM_W + GAMMA_FRAC;
  localparam int DEN_W = W_W - 2;

  // scaling
  localparam int MAG_W  = W_W - 1;
  localparam int PROD_W = MAG_W + GAMMA_W;
  localparam int SC_W   = PROD_W - GAMMA_FRAC + 1;
  localparam int CL_W   = (SC_W > LIM_W + 1) ? SC_W : LIM_W + 1;
  localparam int ROUND  = (2 ** FRAC_BITS) / 2;

  // duty = floor(us * 65535 / 20000) as us * DUTY_MUL >> DUTY_SH
  localparam int DUTY_SH = 30;
  localparam logic [31:0] DUTY_MUL =
    32'((64'd65535 * (64'd1 << DUTY_SH) + 64'd19999) / 64'd20000);
  localparam int DPROD_W = US_W + 32;
  localparam logic [DUTY_W-1:0] DUTY_FULL = 16'hFFFF;

  // register map
  localparam int ADDR_W = 3;
  localparam logic REG_MIN = 1'b0;
  localparam logic REG_MAX = 1'b1;
  localparam logic [CFG_W-1:0] RST_MIN = 15'd1000;
  localparam logic [CFG_W-1:0] RST_MAX = 15'd1990;

  typedef logic [W_W-1:0] wid_t;

  typedef struct packed {
    logic [CFG_W-1:0] min_us;
    logic [CFG_W-1:0] max_us;
  } cfg_t;

  typedef struct packed {
    logic           vld;
    logic           sat;
    logic           scl;
    wid_t [3:0]     f;
  } mix_t;

  typedef struct packed {
    logic [LIM_W-1:0] lim;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                   vld;
    logic                   sat;
    logic [3:0][US_W-1:0]   us;
    logic [3:0][DUTY_W-1:0] duty;
  } res_t;

endpackage

@@ hdl/qxm_in_if.sv @@
interface qxm_in_if;
  logic                             valid;
  logic                             ready;
  logic        [qxm_pkg::IN_W-1:0] throttle;
  logic signed [qxm_pkg::IN_W-1:0] torque_roll;
  logic signed [qxm_pkg::IN_W-1:0] torque_pitch;
  logic signed [qxm_pkg::IN_W-1:0] torque_yaw;

  modport source (output valid, throttle, torque_roll, torque_pitch, torque_yaw,
                  input ready);
  modport sink (input valid, throttle, torque_roll, torque_pitch, torque_yaw,
                output ready);
endinterface

@@ hdl/qxm_out_if.sv @@
interface qxm_out_if;
  logic                         valid;
  logic                         ready;
  logic [qxm_pkg::US_W-1:0]   pulse_front_a;
  logic [qxm_pkg::US_W-1:0]   pulse_front_b;
  logic [qxm_pkg::US_W-1:0]   pulse_rear_a;
  logic [qxm_pkg::US_W-1:0]   pulse_rear_b;
  logic [qxm_pkg::DUTY_W-1:0] duty_one;
  logic [qxm_pkg::DUTY_W-1:0] duty_two;
  logic [qxm_pkg::DUTY_W-1:0] duty_three;
  logic [qxm_pkg::DUTY_W-1:0] duty_four;
  logic                         was_scaled;

  modport source (output valid, pulse_front_a, pulse_front_b, pulse_rear_a,
                  pulse_rear_b, duty_one, duty_two, duty_three, duty_four,
                  was_scaled, input ready);
  modport sink (input valid, pulse_front_a, pulse_front_b, pulse_rear_a,
                pulse_rear_b, duty_one, duty_two, duty_three, duty_four,
                was_scaled, output ready);
endinterface

@@ hdl/qxm_cfg.sv @@
module qxm_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [qxm_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output qxm_pkg::cfg_t                cfg_o
);

  logic [qxm_pkg::CFG_W-1:0] min_q, min_d;
  logic [qxm_pkg::CFG_W-1:0] max_q, max_d;
  logic                      wr;

  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  // register write decode
  always_comb begin
    min_d = min_q;
    max_d = max_q;
    if (wr) begin
      case (paddr[2])
        qxm_pkg::REG_MIN: min_d = pwdata[qxm_pkg::CFG_W-1:0];
        qxm_pkg::REG_MAX: max_d = pwdata[qxm_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= qxm_pkg::RST_MIN;
      max_q <= qxm_pkg::RST_MAX;
    end else begin
      min_q <= min_d;
      max_q <= max_d;
    end
  end

  // read back
  always_comb begin
    case (paddr[2])
      qxm_pkg::REG_MIN: prdata = 32'(min_q);
      qxm_pkg::REG_MAX: prdata = 32'(max_q);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o.min_us = min_q;
  assign cfg_o.max_us = max_q;

endmodule

@@ hdl/qxm_mix.sv @@
module qxm_mix (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             adv_i,
  input  logic                             in_vld_i,
  input  logic        [qxm_pkg::IN_W-1:0] throttle_i,
  input  logic signed [qxm_pkg::IN_W-1:0] roll_i,
  input  logic signed [qxm_pkg::IN_W-1:0] pitch_i,
  input  logic signed [qxm_pkg::IN_W-1:0] yaw_i,
  input  qxm_pkg::cfg_t                    cfg_i,
  output qxm_pkg::mix_t                    mix_o,
  output qxm_pkg::div_req_t                req_o
);

  localparam int CW = qxm_pkg::CMP_W;

  logic signed [CW-1:0] lo, hi;

  // stage A: mixed widths
  logic                 va_q;
  qxm_pkg::wid_t        fa_q [4];
  qxm_pkg::wid_t        fa_d [4];
  // stage B: violations
  logic                 vb_q;
  logic                 satb_q, satb_d;
  qxm_pkg::wid_t        fb_q [4];
  logic [CW-1:0]        vio_q [4];
  logic [CW-1:0]        vio_d [4];
  // stage C: worst motor, gamma operands
  logic                 vc_q;
  qxm_pkg::mix_t        mc_q, mc_d;
  qxm_pkg::div_req_t    rc_q, rc_d;

  assign lo = $signed(CW'(cfg_i.min_us) << qxm_pkg::FRAC_BITS);
  assign hi = $signed(CW'(cfg_i.max_us) << qxm_pkg::FRAC_BITS);

  // quad-X sign matrix
  always_comb begin
    logic signed [qxm_pkg::W_W-1:0] t, r, p, y;
    t = qxm_pkg::W_W'(throttle_i);
    r = qxm_pkg::W_W'(roll_i);
    p = qxm_pkg::W_W'(pitch_i);
    y = qxm_pkg::W_W'(yaw_i);
    fa_d[0] = t - r - p - y;
    fa_d[1] = t - r + p + y;
    fa_d[2] = t + r + p - y;
    fa_d[3] = t + r - p + y;
  end

  // distance outside the window, upper limit tested first
  always_comb begin
    logic signed [CW-1:0] fx;
    satb_d = 1'b0;
    for (int i = 0; i < 4; i++) begin
      fx = CW'($signed(fa_q[i]));
      if (fx > hi)      vio_d[i] = fx - hi;
      else if (fx < lo) vio_d[i] = lo - fx;
      else              vio_d[i] = '0;
      if (fx > hi || fx < lo) satb_d = 1'b1;
    end
  end

  // largest violation, first motor wins a tie
  always_comb begin
    logic [CW-1:0]        worst;
    logic [1:0]           j;
    logic signed [CW-1:0] fj;
    worst = '0;
    j     = '0;
    for (int i = 0; i < 4; i++) begin
      if (vio_q[i] > worst) begin
        worst = vio_q[i];
        j     = 2'(i);
      end
    end
    fj = CW'($signed(fb_q[j]));
    mc_d.vld = vb_q;
    mc_d.sat = satb_q;
    mc_d.scl = satb_q && (fj > 0);
    for (int i = 0; i < 4; i++) mc_d.f[i] = fb_q[i];
    rc_d.lim = (fj > hi) ? qxm_pkg::LIM_W'(hi) : qxm_pkg::LIM_W'(lo);
    rc_d.den = qxm_pkg::DEN_W'(fb_q[j]);
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (adv_i) begin
      va_q <= in_vld_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      fa_q   <= fa_d;
      fb_q   <= fa_q;
      vio_q  <= vio_d;
      satb_q <= satb_d;
      mc_q   <= mc_d;
      rc_q   <= rc_d;
    end
  end

  always_comb begin
    mix_o     = mc_q;
    mix_o.vld = vc_q;
  end
  assign req_o = rc_q;

endmodule

@@ hdl/qxm_div.sv @@
module qxm_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           adv_i,
  input  qxm_pkg::mix_t                  mix_i,
  input  qxm_pkg::div_req_t              req_i,
  output qxm_pkg::mix_t                  mix_o,
  output logic [qxm_pkg::GAMMA_W-1:0]    gamma_o
);

  localparam int NW = qxm_pkg::NUM_W;
  localparam int DW = qxm_pkg::DEN_W;

  // one quotient bit per stage, MSB first
  logic             vld_q [NW];
  qxm_pkg::mix_t    pay_q [NW];
  logic [DW-1:0]    den_q [NW];
  logic [DW-1:0]    rem_q [NW];
  logic [DW-1:0]    rem_d [NW];
  logic [NW-1:0]    num_q [NW];
  logic [NW-1:0]    num_d [NW];
  logic [NW-1:0]    quo_q [NW];
  logic [NW-1:0]    quo_d [NW];

  logic                         vg_q;
  qxm_pkg::mix_t                pg_q;
  logic [qxm_pkg::GAMMA_W-1:0]  g_q, g_d;

  // restoring step for every stage
  always_comb begin
    logic [DW-1:0] rin;
    logic [NW-1:0] nin;
    logic [NW-1:0] qin;
    logic [DW-1:0] din;
    logic [DW:0]   trial;
    for (int k = 0; k < NW; k++) begin
      if (k == 0) begin
        rin = '0;
        nin = NW'(req_i.lim) << qxm_pkg::GAMMA_FRAC;
        qin = '0;
        din = req_i.den;
      end else begin
        rin = rem_q[k-1];
        nin = num_q[k-1];
        qin = quo_q[k-1];
        din = den_q[k-1];
      end
      trial = {rin, nin[NW-1]};
      num_d[k] = nin << 1;
      if (trial >= {1'b0, din}) begin
        rem_d[k] = DW'(trial - {1'b0, din});
        quo_d[k] = {qin[NW-2:0], 1'b1};
      end else begin
        rem_d[k] = DW'(trial);
        quo_d[k] = {qin[NW-2:0], 1'b0};
      end
    end
  end

  // saturate gamma at its format maximum
  assign g_d = (|(quo_q[NW-1] >> qxm_pkg::GAMMA_W)) ? '1
             : qxm_pkg::GAMMA_W'(quo_q[NW-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NW; k++) vld_q[k] <= 1'b0;
      vg_q <= 1'b0;
    end else if (adv_i) begin
      vld_q[0] <= mix_i.vld;
      for (int k = 1; k < NW; k++) vld_q[k] <= vld_q[k-1];
      vg_q <= vld_q[NW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pay_q[0] <= mix_i;
      den_q[0] <= req_i.den;
      for (int k = 1; k < NW; k++) begin
        pay_q[k] <= pay_q[k-1];
        den_q[k] <= den_q[k-1];
      end
      rem_q <= rem_d;
      num_q <= num_d;
      quo_q <= quo_d;
      pg_q  <= pay_q[NW-1];
      g_q   <= g_d;
    end
  end

  always_comb begin
    mix_o     = pg_q;
    mix_o.vld = vg_q;
  end
  assign gamma_o = g_q;

endmodule

@@ hdl/qxm_scale.sv @@
module qxm_scale (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  qxm_pkg::mix_t                 mix_i,
  input  logic [qxm_pkg::GAMMA_W-1:0]   gamma_i,
  input  qxm_pkg::cfg_t                 cfg_i,
  output qxm_pkg::res_t                 res_o
);

  localparam int PW = qxm_pkg::PROD_W;
  localparam int LW = qxm_pkg::CL_W;
  localparam int DP = qxm_pkg::DPROD_W;

  logic signed [LW-1:0] lo, hi;

  // stage M: magnitude times gamma
  logic                 vm_q;
  logic                 satm_q, sclm_q;
  qxm_pkg::wid_t        fm_q [4];
  logic                 neg_q [4];
  logic                 neg_d [4];
  logic [PW-1:0]        prod_q [4];
  logic [PW-1:0]        prod_d [4];
  // stage U: clamp and round to microseconds
  logic                       vu_q;
  logic                       satu_q;
  logic [qxm_pkg::US_W-1:0]   us_q [4];
  logic [qxm_pkg::US_W-1:0]   us_d [4];
  // stage D: duty product
  logic                       vd_q;
  logic                       satd_q;
  logic [qxm_pkg::US_W-1:0]   usd_q [4];
  logic [DP-1:0]              dp_q [4];
  logic [DP-1:0]              dp_d [4];
  // output register
  logic                       vo_q;
  qxm_pkg::res_t              ro_q, ro_d;

  assign lo = $signed(LW'(cfg_i.min_us) << qxm_pkg::FRAC_BITS);
  assign hi = $signed(LW'(cfg_i.max_us) << qxm_pkg::FRAC_BITS);

  always_comb begin
    logic signed [qxm_pkg::W_W-1:0]  fs;
    logic [qxm_pkg::MAG_W-1:0]       mag;
    for (int i = 0; i < 4; i++) begin
      fs        = $signed(mix_i.f[i]);
      neg_d[i]  = fs < 0;
      mag       = neg_d[i] ? qxm_pkg::MAG_W'(-fs) : qxm_pkg::MAG_W'(fs);
      prod_d[i] = PW'(mag) * PW'(gamma_i);
    end
  end

  // round the scaled magnitude half up and restore sign (or take the unscaled width), clamp, round to us
  always_comb begin
    logic [PW-1:0]        rr;
    logic [LW-1:0]        ru;
    logic signed [LW-1:0] sv;
    logic signed [LW-1:0] val;
    logic signed [LW-1:0] c;
    logic [LW-1:0]        cu;
    for (int i = 0; i < 4; i++) begin
      rr = (prod_q[i] + PW'(1 << (qxm_pkg::GAMMA_FRAC - 1))) >> qxm_pkg::GAMMA_FRAC;
      ru = LW'(rr);
      sv = neg_q[i] ? -$signed(ru) : $signed(ru);
      val = sclm_q ? sv : LW'($signed(fm_q[i]));
      if (val < lo)      c = lo;
      else if (val > hi) c = hi;
      else               c = val;
      if (c < 0) c = '0;
      cu = c;
      us_d[i] = qxm_pkg::US_W'((cu + LW'(qxm_pkg::ROUND)) >> qxm_pkg::FRAC_BITS);
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) dp_d[i] = DP'(us_q[i]) * DP'(qxm_pkg::DUTY_MUL);
  end

  // duty word, saturated
  always_comb begin
    logic [DP-1:0] dsh;
    ro_d.vld = vd_q;
    ro_d.sat = satd_q;
    for (int i = 0; i < 4; i++) begin
      dsh = dp_q[i] >> qxm_pkg::DUTY_SH;
      ro_d.us[i]   = usd_q[i];
      ro_d.duty[i] = (dsh > DP'(qxm_pkg::DUTY_FULL)) ? qxm_pkg::DUTY_FULL
                   : qxm_pkg::DUTY_W'(dsh);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
      vu_q <= 1'b0;
      vd_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv_i) begin
      vm_q <= mix_i.vld;
      vu_q <= vm_q;
      vd_q <= vu_q;
      vo_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      satm_q <= mix_i.sat;
      sclm_q <= mix_i.scl;
      for (int i = 0; i < 4; i++) fm_q[i] <= mix_i.f[i];
      neg_q  <= neg_d;
      prod_q <= prod_d;
      satu_q <= satm_q;
      us_q   <= us_d;
      satd_q <= satu_q;
      usd_q  <= us_q;
      dp_q   <= dp_d;
      ro_q   <= ro_d;
    end
  end

  always_comb begin
    res_o     = ro_q;
    res_o.vld = vo_q;
  end

endmodule

@@ hdl/quad_x_mixer_collective_desaturation.sv @@
// Channel   Direction  Transaction
// in_i      sink       throttle, roll, pitch and yaw torques (us * 16)
// out_o     source     four pulse widths (us), four duty words, was_scaled
// APB       slave      min_pulse_us at 0x0, max_pulse_us at 0x4
//
// One transaction enters per cycle unless a result is held at out_o. The gamma
// divider computes one quotient bit per stage. The whole pipeline holds while
// a result waits at out_o, so a stall loses or repeats nothing. Reset clears the
// valid bits and loads the limit registers with 1000 and 1990 us; there is no
// clearing pass.
module quad_x_mixer_collective_desaturation (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  qxm_in_if.sink                        in_i,
  qxm_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qxm_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  qxm_pkg::cfg_t                cfg;
  qxm_pkg::mix_t                mix;
  qxm_pkg::div_req_t            req;
  qxm_pkg::mix_t                dmix;
  logic [qxm_pkg::GAMMA_W-1:0]  gamma;
  qxm_pkg::res_t                res;
  logic                         adv;

  // pipeline moves unless a result is held at the output
  assign adv        = !res.vld || out_o.ready;
  assign in_i.ready = adv;

  qxm_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o (cfg)
  );

  qxm_mix u_mix (
    .clk_i, .rst_ni,
    .adv_i      (adv),
    .in_vld_i   (in_i.valid),
    .throttle_i (in_i.throttle),
    .roll_i     (in_i.torque_roll),
    .pitch_i    (in_i.torque_pitch),
    .yaw_i      (in_i.torque_yaw),
    .cfg_i      (cfg),
    .mix_o      (mix),
    .req_o      (req)
  );

  qxm_div u_div (
    .clk_i, .rst_ni,
    .adv_i   (adv),
    .mix_i   (mix),
    .req_i   (req),
    .mix_o   (dmix),
    .gamma_o (gamma)
  );

  qxm_scale u_scale (
    .clk_i, .rst_ni,
    .adv_i   (adv),
    .mix_i   (dmix),
    .gamma_i (gamma),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  assign out_o.valid         = res.vld;
  assign out_o.pulse_front_a = res.us[0];
  assign out_o.pulse_front_b = res.us[1];
  assign out_o.pulse_rear_a  = res.us[2];
  assign out_o.pulse_rear_b  = res.us[3];
  assign out_o.duty_one      = res.duty[0];
  assign out_o.duty_two      = res.duty[1];
  assign out_o.duty_three    = res.duty[2];
  assign out_o.duty_four     = res.duty[3];
  assign out_o.was_scaled    = res.sat;

  // a held result blocks new input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |-> !in_i.ready)
    else $error("input accepted while output stalled");

  // with an ordered window every width ends up inside it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && cfg.min_us <= cfg.max_us |->
      out_o.pulse_front_a >= cfg.min_us && out_o.pulse_front_a <= cfg.max_us &&
      out_o.pulse_front_b >= cfg.min_us && out_o.pulse_front_b <= cfg.max_us &&
      out_o.pulse_rear_a  >= cfg.min_us && out_o.pulse_rear_a  <= cfg.max_us &&
      out_o.pulse_rear_b  >= cfg.min_us && out_o.pulse_rear_b  <= cfg.max_us)
    else $error("pulse width outside limits");

  // a stalled result keeps its flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.was_scaled))
    else $error("stalled result changed");

endmodule

@@ verif/tb_quad_x_mixer_collective_desaturation.sv @@
`timescale 1ns / 1ps

module tb_quad_x_mixer_collective_desaturation;

  // Number of pipeline registers between input and output.
  localparam int PIPE_LAT = qxm_pkg::NUM_W + 8;
  localparam int CYC_LIMIT = 400000;

  typedef struct packed {
    logic [qxm_pkg::US_W-1:0]   us_a, us_b, us_c, us_d;
    logic [qxm_pkg::DUTY_W-1:0] d1, d2, d3, d4;
    logic                       scaled;
  } motor_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [qxm_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  qxm_in_if  in_ch ();
  qxm_out_if out_ch ();

  quad_x_mixer_collective_desaturation i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  motor_out_t motor_q[$];
  int errors = 0;
  int cycles = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  logic [14:0] lim_min_us = 15'd1000;
  logic [14:0] lim_max_us = 15'd1990;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.throttle = '0;
    in_ch.torque_roll = '0;
    in_ch.torque_pitch = '0;
    in_ch.torque_yaw = '0;
    out_ch.ready = 1'b0;
  end

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Cycle counter and timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("tb_quad_x_mixer_collective_desaturation: FAIL");
      $finish;
    end
  end

  // Mixer prediction: mix, desaturate by gamma, clamp, round, duty word
  function automatic motor_out_t mix_motors(logic [14:0] thr, logic [14:0] rl,
                                            logic [14:0] pt, logic [14:0] yw);
    longint t, r, p, y, lo, hi, worst, v, lim, c;
    longint f[4];
    longint unsigned g, mag, us, duty;
    bit sat;
    int j;
    logic [qxm_pkg::US_W-1:0] us_v[4];
    logic [qxm_pkg::DUTY_W-1:0] du_v[4];
    motor_out_t o;
    t = thr;
    r = longint'(signed'(rl));
    p = longint'(signed'(pt));
    y = longint'(signed'(yw));
    lo = longint'(lim_min_us) <<< qxm_pkg::FRAC_BITS;
    hi = longint'(lim_max_us) <<< qxm_pkg::FRAC_BITS;
    f[0] = t - r - p - y;
    f[1] = t - r + p + y;
    f[2] = t + r + p - y;
    f[3] = t + r - p + y;
    sat = 0;
    for (int i = 0; i < 4; i++) if (f[i] < lo || f[i] > hi) sat = 1;
    if (sat) begin
      worst = 0;
      j = 0;
      lim = 0;
      for (int i = 0; i < 4; i++) begin
        v = 0;
        if (f[i] > hi) v = f[i] - hi;
        else if (f[i] < lo) v = lo - f[i];
        if (v > worst) begin
          worst = v;
          j = i;
        end
      end
      lim = (f[j] > hi) ? hi : lo;
      if ((f[j] > hi || f[j] < lo) && f[j] > 0) begin
        g = (longint'(lim) << qxm_pkg::GAMMA_FRAC) / f[j];
        if (g > 64'hFFFF_FFFF) g = 64'hFFFF_FFFF;
        for (int i = 0; i < 4; i++) begin
          mag = (f[i] < 0) ? -f[i] : f[i];
          mag = (mag * g + (64'd1 << (qxm_pkg::GAMMA_FRAC - 1))) >> qxm_pkg::GAMMA_FRAC;
          f[i] = (f[i] < 0) ? -longint'(mag) : longint'(mag);
        end
      end
    end
    for (int i = 0; i < 4; i++) begin
      c = f[i];
      if (c < lo) c = lo;
      else if (c > hi) c = hi;
      if (c < 0) c = 0;
      us = (longint'(c) + qxm_pkg::ROUND) >> qxm_pkg::FRAC_BITS;
      us &= 64'h7FFF;
      duty = us * 65535 / 20000;
      if (duty > 65535) duty = 65535;
      us_v[i] = us[qxm_pkg::US_W-1:0];
      du_v[i] = duty[qxm_pkg::DUTY_W-1:0];
    end
    o.us_a = us_v[0]; o.us_b = us_v[1]; o.us_c = us_v[2]; o.us_d = us_v[3];
    o.d1 = du_v[0]; o.d2 = du_v[1]; o.d3 = du_v[2]; o.d4 = du_v[3];
    o.scaled = sat;
    return o;
  endfunction

  // Result checker and receiver stall
  always @(posedge clk_i) begin
    motor_out_t e;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (motor_q.size() == 0) begin
          $error("result transaction with nothing expected");
          errors++;
        end else begin
          e = motor_q.pop_front();
          if (out_ch.pulse_front_a !== e.us_a) begin
            $error("pulse_front_a exp %0d got %0d", e.us_a, out_ch.pulse_front_a); errors++;
          end
          if (out_ch.pulse_front_b !== e.us_b) begin
            $error("pulse_front_b exp %0d got %0d", e.us_b, out_ch.pulse_front_b); errors++;
          end
          if (out_ch.pulse_rear_a !== e.us_c) begin
            $error("pulse_rear_a exp %0d got %0d", e.us_c, out_ch.pulse_rear_a); errors++;
          end
          if (out_ch.pulse_rear_b !== e.us_d) begin
            $error("pulse_rear_b exp %0d got %0d", e.us_d, out_ch.pulse_rear_b); errors++;
          end
          if (out_ch.duty_one !== e.d1) begin
            $error("duty_one exp %0d got %0d", e.d1, out_ch.duty_one); errors++;
          end
          if (out_ch.duty_two !== e.d2) begin
            $error("duty_two exp %0d got %0d", e.d2, out_ch.duty_two); errors++;
          end
          if (out_ch.duty_three !== e.d3) begin
            $error("duty_three exp %0d got %0d", e.d3, out_ch.duty_three); errors++;
          end
          if (out_ch.duty_four !== e.d4) begin
            $error("duty_four exp %0d got %0d", e.d4, out_ch.duty_four); errors++;
          end
          if (out_ch.was_scaled !== e.scaled) begin
            $error("was_scaled exp %0d got %0d", e.scaled, out_ch.was_scaled); errors++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // One input transaction; prediction taken at acceptance
  task automatic send_mix(logic [14:0] thr, logic [14:0] rl, logic [14:0] pt,
                          logic [14:0] yw);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.throttle <= thr;
    in_ch.torque_roll <= rl;
    in_ch.torque_pitch <= pt;
    in_ch.torque_yaw <= yw;
    do @(posedge clk_i); while (!in_ch.ready);
    motor_q.push_back(mix_motors(thr, rl, pt, yw));
  endtask

  // Stop sending and wait for every expected result
  task automatic wait_empty();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (motor_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic drain_results();
    wait_empty();
    repeat (PIPE_LAT + 10) @(posedge clk_i);
  endtask

  // APB write: setup phase, then access phase, then idle
  task automatic write_limit(logic [qxm_pkg::ADDR_W-1:0] addr, logic [14:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= addr; pwdata <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == qxm_pkg::ADDR_W'(4 * qxm_pkg::REG_MIN)) lim_min_us = val;
    else lim_max_us = val;
    @(posedge clk_i);
  endtask

  task automatic set_limits(logic [14:0] lo, logic [14:0] hi);
    drain_results();
    write_limit(qxm_pkg::ADDR_W'(4 * qxm_pkg::REG_MIN), lo);
    write_limit(qxm_pkg::ADDR_W'(4 * qxm_pkg::REG_MAX), hi);
  endtask

  function automatic logic [14:0] rnd_torque(int span);
    int v;
    v = $urandom_range(2 * span) - span;
    return 15'(v);
  endfunction

  // Directed: field extremes, inside, above, below, zero worst, min above max
  task automatic test_directed();
    send_mix(15'd24000, 15'd0, 15'd0, 15'd0);
    send_mix(15'd0, 15'd0, 15'd0, 15'd0);
    send_mix(15'd32000, 15'd0, 15'd0, 15'd0);
    send_mix(15'd32767, 15'h7FFF, 15'h7FFF, 15'h7FFF);
    send_mix(15'd24000, 15'd800, 15'd0, 15'd0);
    send_mix(15'd24000, -15'sd800, 15'd400, -15'sd400);
    send_mix(15'd31000, 15'd16000, -15'sd16000, 15'd16000);
    send_mix(15'd0, -15'sd16000, -15'sd16000, -15'sd16000);
    send_mix(15'd0, 15'd16000, 15'd16000, 15'd16000);
    send_mix(15'd1000, 15'd200, 15'd200, 15'd200);
    send_mix(15'd16000, 15'h4000, 15'h4000, 15'h4000);
    send_mix(15'd20000, 15'h5555, 15'h2AAA, 15'h1234);
    set_limits(15'd0, 15'd20000);
    send_mix(15'd32000, 15'd0, 15'd0, 15'd0);
    send_mix(15'd0, 15'd16000, 15'd16000, -15'sd16000);
    send_mix(15'd32767, -15'sd16000, -15'sd16000, -15'sd16000);
    set_limits(15'h7FFF, 15'h7FFF);
    send_mix(15'd20000, 15'd100, 15'd0, 15'd0);
    set_limits(15'd1800, 15'd1200);
    send_mix(15'd24000, 15'd3000, 15'd0, 15'd0);
    send_mix(15'd24000, 15'd0, 15'd0, 15'd0);
    set_limits(15'd0, 15'd0);
    send_mix(15'd16000, 15'd100, 15'd100, 15'd100);
    set_limits(15'd1000, 15'd1990);
  endtask

  // Random: mostly plausible flight commands, some full-range noise
  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 7)
        send_mix(15'($urandom_range(32000)), rnd_torque($urandom_range(4000)),
                 rnd_torque($urandom_range(4000)), rnd_torque($urandom_range(2000)));
      else
        send_mix(15'($urandom), 15'($urandom), 15'($urandom), 15'($urandom));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    src_idle_pct = 18; snk_idle_pct = 61;
    test_random(200);
    // hold off until the pipeline is empty
    wait_empty();
    test_random(20);
    set_limits(15'd1100, 15'd1900);
    src_idle_pct = 61; snk_idle_pct = 18;
    test_random(200);
    set_limits(15'($urandom_range(2000)), 15'($urandom_range(20000)));
    src_idle_pct = 0; snk_idle_pct = 0;
    test_random(200);
    drain_results();
    if (errors == 0) begin
      $display("tb_quad_x_mixer_collective_desaturation: PASS");
    end else begin
      $display("tb_quad_x_mixer_collective_desaturation: FAIL");
    end
    $finish;
  end

endmodule
